// ----- design/vdp_pkg.sv -----
package vdp_pkg;

    // Host address space of the access port.
    localparam int ADDR_W = 14;
    localparam logic [ADDR_W-1:0] ADDR_MAX = 14'h3FFF;

    // Register file size and the register that reloads the line counter.
    localparam int NUM_REGS = 11;
    localparam int LINE_REG = 10;

    localparam logic [7:0] LINE_CNT_RESET = 8'hFF;
    localparam logic [7:0] FRAME_FLAG = 8'h80;

    // Colour memory contents after reset: this palette, then zeros.
    localparam int PALETTE_LEN = 16;
    localparam logic [7:0] BOOT_PALETTE [PALETTE_LEN] = '{
        8'h00, 8'h00, 8'h08, 8'h0C, 8'h20, 8'h30, 8'h02, 8'h3C,
        8'h03, 8'h17, 8'h0A, 8'h1F, 8'h04, 8'h33, 8'h2A, 8'h3F
    };

    // Item modes.
    typedef enum logic [2:0] {
        MODE_DATA_WR   = 3'd0,
        MODE_DATA_RD   = 3'd1,
        MODE_CTRL_WR   = 3'd2,
        MODE_STATUS_RD = 3'd3,
        MODE_TICK      = 3'd4
    } t_mode;

    // Access codes set by the second control byte.
    typedef enum logic [1:0] {
        CODE_VRAM_RD = 2'd0,
        CODE_VRAM_WR = 2'd1,
        CODE_REG_WR  = 2'd2,
        CODE_CRAM_WR = 2'd3
    } t_code;

    // Datapath operations, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LATCH,
        OP_DATA_WR,
        OP_VREAD,
        OP_DATA_RD,
        OP_CTRL_FIRST,
        OP_CTRL_SECOND,
        OP_MOD_STEP,
        OP_PREFETCH,
        OP_STATUS,
        OP_TICK,
        OP_RESULT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        t_code      code;
        logic       second_byte;
        logic       clear_last;
    } t_status;

endpackage

// ----- design/vdp_if.sv -----
// Input channel: one host access or scanline tick per word.
interface vdp_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic [8:0] line_number;

    modport source (output valid, output mode, output data_byte, output line_number,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input line_number,
                    output ready);
endinterface

// Output channel: one result word per item.
interface vdp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_value;
    logic       frame_irq_pending;
    logic       line_irq_pending;

    modport source (output valid, output read_value, output frame_irq_pending,
                    output line_irq_pending, input ready);
    modport sink   (input valid, input read_value, input frame_irq_pending,
                    input line_irq_pending, output ready);
endinterface

// ----- design/vdp_dpath.sv -----
module vdp_dpath #(
    parameter int VIDEO_MEM_DEPTH  = 16384,
    parameter int COLOUR_MEM_DEPTH = 32,
    parameter int ACTIVE_LINES     = 192
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vdp_pkg::t_cmd    i_cmd,
    output vdp_pkg::t_status o_status,
    input  logic [2:0]       i_mode,
    input  logic [7:0]       i_data_byte,
    input  logic [8:0]       i_line_number,
    output logic [7:0]       o_read_value,
    output logic             o_frame_irq_pending,
    output logic             o_line_irq_pending
);

    localparam int AW  = vdp_pkg::ADDR_W;
    localparam int VAW = $clog2(VIDEO_MEM_DEPTH);
    localparam int CAW = $clog2(COLOUR_MEM_DEPTH);

    // Reciprocal multiplication for the address remainders. The shift covers the
    // address width plus the ceiling log2 of the depth, so the truncated quotient is exact.
    localparam int RW   = AW + 2;
    localparam int PW   = AW + RW;
    localparam int V_SH = AW + VAW;
    localparam int C_SH = AW + CAW;
    localparam longint V_ONE = longint'(1) << V_SH;
    localparam longint C_ONE = longint'(1) << C_SH;
    localparam logic [RW-1:0] V_RECIP =
        RW'((V_ONE + longint'(VIDEO_MEM_DEPTH) - 1) / longint'(VIDEO_MEM_DEPTH));
    localparam logic [RW-1:0] C_RECIP =
        RW'((C_ONE + longint'(COLOUR_MEM_DEPTH) - 1) / longint'(COLOUR_MEM_DEPTH));

    localparam logic [VAW-1:0]   V_LAST     = VAW'(VIDEO_MEM_DEPTH - 1);
    localparam logic [CAW-1:0]   C_LAST     = CAW'(COLOUR_MEM_DEPTH - 1);
    localparam logic [8:0]       LAST_LINE  = 9'(ACTIVE_LINES);

    // Memories.
    logic [7:0] r_vmem [VIDEO_MEM_DEPTH];
    logic [7:0] r_cmem [COLOUR_MEM_DEPTH];

    // Access state.
    logic [AW-1:0]       r_addr;
    logic [VAW-1:0]      r_vidx;
    logic [CAW-1:0]      r_cidx;
    vdp_pkg::t_code      r_code;
    logic [7:0]          r_latch;
    logic                r_sbe;
    logic [7:0]          r_read_buf;
    logic [7:0]          r_status;
    logic [7:0]          r_line_cnt;
    logic                r_frame;
    logic                r_line_pend;
    logic [7:0]          r_regs [vdp_pkg::NUM_REGS];
    logic [VAW-1:0]      r_clr;

    // Current item and result.
    logic [2:0]          r_mode;
    logic [7:0]          r_byte;
    logic [8:0]          r_line;
    logic [7:0]          r_result;
    logic [7:0]          r_out_value;
    logic                r_out_frame;
    logic                r_out_line;

    // Remainder unit.
    logic [PW-1:0]       r_vprod;
    logic [PW-1:0]       r_cprod;

    logic [AW-1:0]       vquo;
    logic [AW-1:0]       cquo;
    logic [PW-1:0]       vmul;
    logic [PW-1:0]       cmul;
    logic [AW-1:0]       vrem;
    logic [AW-1:0]       crem;

    logic [AW-1:0]       addr_inc;
    logic [VAW-1:0]      vidx_inc;
    logic [CAW-1:0]      cidx_inc;
    logic                code_vram;
    logic [AW-1:0]       ctrl_addr;
    logic                reg_sel_ok;

    logic                vmem_we;
    logic [VAW-1:0]      vmem_waddr;
    logic [7:0]          vmem_wdata;
    logic                vmem_re;
    logic                cmem_we;
    logic [CAW-1:0]      cmem_waddr;
    logic [7:0]          cmem_wdata;
    logic                clr_in_cmem;

    // Quotients from the registered products, then the remainders of the address.
    always_comb begin
        vquo = AW'(r_vprod >> V_SH);
        cquo = AW'(r_cprod >> C_SH);
        vmul = PW'(vquo) * PW'(VIDEO_MEM_DEPTH);
        cmul = PW'(cquo) * PW'(COLOUR_MEM_DEPTH);
        vrem = r_addr - vmul[AW-1:0];
        crem = r_addr - cmul[AW-1:0];
    end

    // Address increment with wrap, tracking both memory indexes.
    always_comb begin
        addr_inc = r_addr + 1'b1;
        if (r_addr == vdp_pkg::ADDR_MAX) begin
            vidx_inc = '0;
            cidx_inc = '0;
        end else begin
            vidx_inc = (r_vidx == V_LAST) ? '0 : r_vidx + 1'b1;
            cidx_inc = (r_cidx == C_LAST) ? '0 : r_cidx + 1'b1;
        end
    end

    assign code_vram  = (r_code == vdp_pkg::CODE_VRAM_RD) || (r_code == vdp_pkg::CODE_VRAM_WR);
    assign ctrl_addr  = {r_byte[5:0], r_latch};
    assign reg_sel_ok = (r_byte[7:6] == vdp_pkg::CODE_REG_WR) &&
                        (r_byte[3:0] < 4'(vdp_pkg::NUM_REGS));

    // Memory port control.
    always_comb begin
        clr_in_cmem = (r_clr < VAW'(COLOUR_MEM_DEPTH));
        vmem_we     = 1'b0;
        vmem_waddr  = r_vidx;
        vmem_wdata  = r_byte;
        cmem_we     = 1'b0;
        cmem_waddr  = r_cidx;
        cmem_wdata  = r_byte;
        vmem_re     = (i_cmd.op == vdp_pkg::OP_VREAD) || (i_cmd.op == vdp_pkg::OP_DATA_RD) ||
                      (i_cmd.op == vdp_pkg::OP_PREFETCH);
        case (i_cmd.op)
            vdp_pkg::OP_CLEAR: begin
                vmem_we    = 1'b1;
                vmem_waddr = r_clr;
                vmem_wdata = '0;
                cmem_we    = clr_in_cmem;
                cmem_waddr = r_clr[CAW-1:0];
                cmem_wdata = (r_clr < VAW'(vdp_pkg::PALETTE_LEN)) ?
                             vdp_pkg::BOOT_PALETTE[r_clr[3:0]] : 8'h00;
            end
            vdp_pkg::OP_DATA_WR: begin
                vmem_we = code_vram;
                cmem_we = (r_code == vdp_pkg::CODE_CRAM_WR);
            end
            default: begin
            end
        endcase
    end

    // Video memory write port.
    always_ff @(posedge i_clk) begin
        if (vmem_we) begin
            r_vmem[vmem_waddr] <= vmem_wdata;
        end
    end

    // Video memory read port; its output register is the read buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_buf <= '0;
        end else if (vmem_re) begin
            r_read_buf <= r_vmem[r_vidx];
        end
    end

    // Colour memory write port.
    always_ff @(posedge i_clk) begin
        if (cmem_we) begin
            r_cmem[cmem_waddr] <= cmem_wdata;
        end
    end

    // Access, interrupt and register state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_addr      <= '0;
            r_vidx      <= '0;
            r_cidx      <= '0;
            r_code      <= vdp_pkg::CODE_VRAM_RD;
            r_latch     <= '0;
            r_sbe       <= 1'b0;
            r_status    <= '0;
            r_line_cnt  <= vdp_pkg::LINE_CNT_RESET;
            r_frame     <= 1'b0;
            r_line_pend <= 1'b0;
            r_regs      <= '{default: '0};
        end else begin
            case (i_cmd.op)
                vdp_pkg::OP_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                end
                vdp_pkg::OP_DATA_WR: begin
                    r_sbe <= 1'b0;
                    if (r_code != vdp_pkg::CODE_REG_WR) begin
                        r_addr <= addr_inc;
                        r_vidx <= vidx_inc;
                        r_cidx <= cidx_inc;
                    end
                end
                vdp_pkg::OP_DATA_RD: begin
                    r_sbe  <= 1'b0;
                    r_addr <= addr_inc;
                    r_vidx <= vidx_inc;
                    r_cidx <= cidx_inc;
                end
                vdp_pkg::OP_PREFETCH: begin
                    r_addr <= addr_inc;
                    r_vidx <= vidx_inc;
                    r_cidx <= cidx_inc;
                end
                vdp_pkg::OP_CTRL_FIRST: begin
                    r_latch <= r_byte;
                    r_sbe   <= 1'b1;
                end
                vdp_pkg::OP_CTRL_SECOND: begin
                    r_sbe  <= 1'b0;
                    r_code <= vdp_pkg::t_code'(r_byte[7:6]);
                    r_addr <= ctrl_addr;
                    if (reg_sel_ok) begin
                        r_regs[r_byte[3:0]] <= r_latch;
                    end
                end
                vdp_pkg::OP_MOD_STEP: begin
                    r_vidx <= VAW'(vrem);
                    r_cidx <= CAW'(crem);
                end
                vdp_pkg::OP_STATUS: begin
                    r_status    <= '0;
                    r_frame     <= 1'b0;
                    r_line_pend <= 1'b0;
                end
                vdp_pkg::OP_TICK: begin
                    if (r_line <= LAST_LINE) begin
                        if (r_line_cnt == '0) begin
                            r_line_cnt  <= r_regs[vdp_pkg::LINE_REG];
                            r_line_pend <= 1'b1;
                        end else begin
                            r_line_cnt <= r_line_cnt - 8'd1;
                        end
                    end else begin
                        r_line_cnt <= r_regs[vdp_pkg::LINE_REG];
                    end
                    if (r_line == LAST_LINE) begin
                        r_status <= r_status | vdp_pkg::FRAME_FLAG;
                        r_frame  <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Item, result and quotient product registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            vdp_pkg::OP_LATCH: begin
                r_mode   <= i_mode;
                r_byte   <= i_data_byte;
                r_line   <= i_line_number;
                r_result <= '0;
            end
            vdp_pkg::OP_DATA_RD: begin
                r_result <= r_read_buf;
            end
            vdp_pkg::OP_STATUS: begin
                r_result <= r_status;
            end
            vdp_pkg::OP_CTRL_SECOND: begin
                r_vprod <= PW'(ctrl_addr) * PW'(V_RECIP);
                r_cprod <= PW'(ctrl_addr) * PW'(C_RECIP);
            end
            vdp_pkg::OP_RESULT: begin
                r_out_value <= r_result;
                r_out_frame <= r_frame;
                r_out_line  <= r_line_pend;
            end
            default: begin
            end
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_status.mode        = r_mode;
        o_status.code        = r_code;
        o_status.second_byte = r_sbe;
        o_status.clear_last  = (r_clr == V_LAST);
    end

    assign o_read_value        = r_out_value;
    assign o_frame_irq_pending = r_out_frame;
    assign o_line_irq_pending  = r_out_line;

    // A data read moves the address on by one, with wrap.
    a_read_bumps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == vdp_pkg::OP_DATA_RD) |=> (r_addr == AW'($past(r_addr) + 1'b1)))
        else $error("data read did not advance the address");

    // The frame interrupt is never pending without its status flag.
    a_frame_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame |-> r_status[7])
        else $error("frame interrupt pending with status flag clear");

    // A first control byte always arms the second.
    a_first_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == vdp_pkg::OP_CTRL_FIRST) |=> r_sbe)
        else $error("first control byte did not arm the second");

endmodule

// ----- design/vdp_ctrl.sv -----
module vdp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  vdp_pkg::t_status i_status,
    output vdp_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_VREAD,
        S_MOD,
        S_PRE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath command.
    always_comb begin
        n_state  = r_state;
        o_cmd.op = vdp_pkg::OP_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = vdp_pkg::OP_CLEAR;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = vdp_pkg::OP_LATCH;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (i_status.mode)
                    vdp_pkg::MODE_DATA_WR: begin
                        o_cmd.op = vdp_pkg::OP_DATA_WR;
                        if ((i_status.code == vdp_pkg::CODE_VRAM_RD) ||
                            (i_status.code == vdp_pkg::CODE_VRAM_WR)) begin
                            n_state = S_VREAD;
                        end
                    end
                    vdp_pkg::MODE_DATA_RD: begin
                        o_cmd.op = vdp_pkg::OP_DATA_RD;
                    end
                    vdp_pkg::MODE_CTRL_WR: begin
                        if (i_status.second_byte) begin
                            o_cmd.op = vdp_pkg::OP_CTRL_SECOND;
                            n_state  = S_MOD;
                        end else begin
                            o_cmd.op = vdp_pkg::OP_CTRL_FIRST;
                        end
                    end
                    vdp_pkg::MODE_STATUS_RD: begin
                        o_cmd.op = vdp_pkg::OP_STATUS;
                    end
                    vdp_pkg::MODE_TICK: begin
                        o_cmd.op = vdp_pkg::OP_TICK;
                    end
                    default: begin
                    end
                endcase
            end
            S_VREAD: begin
                o_cmd.op = vdp_pkg::OP_VREAD;
                n_state  = S_DONE;
            end
            S_MOD: begin
                o_cmd.op = vdp_pkg::OP_MOD_STEP;
                n_state  = (i_status.code == vdp_pkg::CODE_VRAM_RD) ? S_PRE : S_DONE;
            end
            S_PRE: begin
                o_cmd.op = vdp_pkg::OP_PREFETCH;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.op = vdp_pkg::OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output word valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.op == vdp_pkg::OP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // An accepted word is decoded in the next cycle.
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted word not decoded");

    // A result word appears only when an item finishes.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result word raised outside item completion");

    // The remainder step leaves for the prefetch or the finish.
    a_mod_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |=> ((r_state == S_PRE) || (r_state == S_DONE)))
        else $error("remainder step did not end");

endmodule

// ----- design/vdp_port_and_line_irq_unit.sv -----
// Channel   Dir  Word fields                                       Handshake
// i_in      in   mode[2:0], data_byte[7:0], line_number[8:0]       valid/ready
// o_out     out  read_value[7:0], frame_irq_pending, line_irq_pending  valid/ready
//
// One item at a time: each is latched, decoded and finished. A data write with a video
// memory code adds a read step (write, then prefetch), and a second control byte adds a
// remainder step (index by reciprocal remainder), then a prefetch for a video read code.
// After reset a clearing pass over all video memory zeroes it and loads the palette;
// no word is accepted until it ends. A new word is taken while the last result still
// waits in the output register; a stalled output holds the item's finish.
module vdp_port_and_line_irq_unit #(
    parameter int VIDEO_MEM_DEPTH  = 16384,
    parameter int COLOUR_MEM_DEPTH = 32,
    parameter int ACTIVE_LINES     = 192
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vdp_in_if.sink     i_in,
    vdp_out_if.source  o_out
);

    vdp_pkg::t_cmd    cmd;
    vdp_pkg::t_status status;
    logic             in_ready;
    logic             out_valid;

    // Sequencer.
    vdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Memories, access state and interrupt logic.
    vdp_dpath #(
        .VIDEO_MEM_DEPTH  (VIDEO_MEM_DEPTH),
        .COLOUR_MEM_DEPTH (COLOUR_MEM_DEPTH),
        .ACTIVE_LINES     (ACTIVE_LINES)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_mode              (i_in.mode),
        .i_data_byte         (i_in.data_byte),
        .i_line_number       (i_in.line_number),
        .o_read_value        (o_out.read_value),
        .o_frame_irq_pending (o_out.frame_irq_pending),
        .o_line_irq_pending  (o_out.line_irq_pending)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule
